// ===== rtl/core/pctt_pkg.sv =====
package pctt_pkg;

    // Table geometry; the slot field is four bits wide, so the table size is fixed here
    localparam int SLOTS  = 8;
    localparam int SLOT_W = 4;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Repeat count that means the channel never stops
    localparam logic [15:0] FOREVER_CODE = 16'hFFFF;

    // Command codes
    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_REG  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [15:0] repeat_count;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fired;
        logic [15:0]       repeats_left;
        logic              last;
    } t_out_item;

    // One channel entry as stored in the table memory
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] period;
        logic [15:0] repeats;
        logic        running;
    } t_entry;

    // Outcome of checking one channel against the current time
    typedef struct packed {
        logic   fire;
        t_entry entry;
    } t_eval;

endpackage

// ===== rtl/core/pctt_slot_eval.sv =====
module pctt_slot_eval (
    input  pctt_pkg::t_entry i_entry,
    input  logic [31:0]      i_now,
    output pctt_pkg::t_eval  o_eval
);

    logic [31:0] elapsed;
    logic        due;
    logic        endless;
    logic [15:0] dec_repeats;

    // Elapsed time wraps modulo 2^32
    assign elapsed     = i_now - i_entry.start_time;
    assign due         = i_entry.running && (elapsed >= i_entry.period);
    assign endless     = (i_entry.repeats == pctt_pkg::FOREVER_CODE);
    assign dec_repeats = i_entry.repeats - 16'd1;

    // Advance the start time and count down unless endless
    always_comb begin
        o_eval.fire             = due;
        o_eval.entry.start_time = i_entry.start_time + i_entry.period;
        o_eval.entry.period     = i_entry.period;
        if (endless) begin
            o_eval.entry.repeats = i_entry.repeats;
            o_eval.entry.running = 1'b1;
        end else begin
            o_eval.entry.repeats = dec_repeats;
            o_eval.entry.running = (dec_repeats != 16'd0);
        end
    end

endmodule

// ===== rtl/core/periodic_callback_timer_table.sv =====
// Periodic timer-channel table. A register transaction claims the next free slot and
// answers in the cycle after it is taken, with slot 0 when the table is full. A poll
// transaction walks the used slots through the table memory, one slot per cycle (one read,
// check and write-back pipelined over the single-port-read memory), and keeps busy high while
// it scans the slots and flushes the final result; a poll with no slots in use answers in
// the cycle after it is taken. Results appear on o_result with o_strobe for exactly one cycle
// each and cannot be held off, so the receiver must take every strobed result. Fired results
// come out in slot order, one at most per cycle, the final one marked by last; a poll that
// fires nothing gives a single empty result.
module periodic_callback_timer_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pctt_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output pctt_pkg::t_out_item  o_result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam int SLOT_W = pctt_pkg::SLOT_W;
    localparam int IDX_W  = pctt_pkg::IDX_W;

    // Channel table
    pctt_pkg::t_entry mem [pctt_pkg::SLOTS];

    logic [1:0]          r_state;
    logic [SLOT_W-1:0]   r_used;
    logic [IDX_W-1:0]    r_idx;
    logic [31:0]         r_now;
    logic                r_pend_vld;
    pctt_pkg::t_out_item r_pend;
    logic                r_out_vld;
    pctt_pkg::t_out_item r_out;
    pctt_pkg::t_entry    r_rd_data;

    logic                accept;
    logic                full;
    logic                last_slot;
    logic [SLOT_W-1:0]   cur_slot;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    pctt_pkg::t_entry    wr_data;
    pctt_pkg::t_eval     eval;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && (r_state == ST_IDLE);
    assign full      = (r_used >= SLOT_W'(pctt_pkg::SLOTS));
    assign cur_slot  = SLOT_W'(r_idx) + SLOT_W'(1);
    assign last_slot = (cur_slot == r_used);

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    // Check the slot whose entry was read last cycle
    pctt_slot_eval u_eval (
        .i_entry (r_rd_data),
        .i_now   (r_now),
        .o_eval  (eval)
    );

    // Read the next slot while the current one is checked
    assign rd_addr = (r_state == ST_SCAN) ? (r_idx + IDX_W'(1)) : '0;

    // Write a new channel on register, or write back a fired channel
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = eval.entry;
        if (accept && (i_item.cmd == pctt_pkg::CMD_REG) && !full) begin
            wr_en              = 1'b1;
            wr_addr            = r_used[IDX_W-1:0];
            wr_data.start_time = i_item.now_ms;
            wr_data.period     = i_item.period_ms;
            wr_data.repeats    = i_item.repeat_count;
            wr_data.running    = 1'b1;
        end else if ((r_state == ST_SCAN) && eval.fire) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Sequence register and poll transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used     <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_item.cmd == pctt_pkg::CMD_REG) begin
                            r_out_vld          <= 1'b1;
                            r_out.fired        <= 1'b0;
                            r_out.repeats_left <= '0;
                            r_out.last         <= 1'b1;
                            if (full) begin
                                r_out.slot <= '0;
                            end else begin
                                r_out.slot <= r_used + SLOT_W'(1);
                                r_used     <= r_used + SLOT_W'(1);
                            end
                        end else begin
                            r_now      <= i_item.now_ms;
                            r_pend_vld <= 1'b0;
                            r_idx      <= '0;
                            if (r_used == '0) begin
                                r_out_vld          <= 1'b1;
                                r_out.slot         <= '0;
                                r_out.fired        <= 1'b0;
                                r_out.repeats_left <= '0;
                                r_out.last         <= 1'b1;
                            end else begin
                                r_out_vld <= 1'b0;
                                r_state   <= ST_SCAN;
                            end
                        end
                    end else begin
                        r_out_vld <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // Hold each fire until the next one shows it was not the final one
                    r_out_vld <= eval.fire && r_pend_vld;
                    if (eval.fire) begin
                        if (r_pend_vld) begin
                            r_out <= r_pend;
                        end
                        r_pend_vld          <= 1'b1;
                        r_pend.slot         <= cur_slot;
                        r_pend.fired        <= 1'b1;
                        r_pend.repeats_left <= eval.entry.repeats;
                        r_pend.last         <= 1'b0;
                    end
                    if (last_slot) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_FLUSH: begin
                    // Emit the held fire as final, or an empty result
                    r_out_vld <= 1'b1;
                    if (r_pend_vld) begin
                        r_out.slot         <= r_pend.slot;
                        r_out.fired        <= r_pend.fired;
                        r_out.repeats_left <= r_pend.repeats_left;
                        r_out.last         <= 1'b1;
                    end else begin
                        r_out.slot         <= '0;
                        r_out.fired        <= 1'b0;
                        r_out.repeats_left <= '0;
                        r_out.last         <= 1'b1;
                    end
                    r_pend_vld <= 1'b0;
                    r_state    <= ST_IDLE;
                end
                default: begin
                    r_out_vld <= 1'b0;
                    r_state   <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== bench/periodic_callback_timer_table_tb.sv =====
`timescale 1ns / 1ps

module periodic_callback_timer_table_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SLOTS         = pctt_pkg::SLOTS;
    localparam int SLOT_W        = pctt_pkg::SLOT_W;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 4;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    pctt_pkg::t_in_item  i_item = '0;
    logic                o_strobe;
    pctt_pkg::t_out_item o_result;

    // Shadow copy of the channel table
    int          ch_used = 0;
    logic [31:0] ch_start   [SLOTS];
    logic [31:0] ch_period  [SLOTS];
    logic [15:0] ch_left    [SLOTS];
    logic        ch_running [SLOTS];

    // Timer results still owed by the block, oldest first
    pctt_pkg::t_out_item due_results_q[$];

    int errors       = 0;
    int cycle_count  = 0;
    int reg_sent     = 0;
    int poll_sent    = 0;
    int results_seen = 0;
    int fires_seen   = 0;
    int rejects_seen = 0;
    int idle_pct     = 7;

    periodic_callback_timer_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Work out the results of one accepted transaction and advance the shadow table
    function automatic void predict_timer_results(pctt_pkg::t_in_item cmd_item);
        pctt_pkg::t_out_item res;
        logic [31:0]         elapsed;
        int                  fires;
        fires = 0;
        res   = '0;
        if (cmd_item.cmd == pctt_pkg::CMD_REG) begin
            reg_sent++;
            res.last = 1'b1;
            if (ch_used < SLOTS) begin
                ch_start[ch_used]   = cmd_item.now_ms;
                ch_period[ch_used]  = cmd_item.period_ms;
                ch_left[ch_used]    = cmd_item.repeat_count;
                ch_running[ch_used] = 1'b1;
                ch_used++;
                res.slot = SLOT_W'(ch_used);
            end else begin
                rejects_seen++;
            end
            due_results_q.push_back(res);
            return;
        end
        poll_sent++;
        for (int i = 0; i < ch_used; i++) begin
            elapsed = cmd_item.now_ms - ch_start[i];
            if (ch_running[i] && elapsed >= ch_period[i]) begin
                if (ch_left[i] != pctt_pkg::FOREVER_CODE) begin
                    ch_left[i] = ch_left[i] - 16'd1;
                    if (ch_left[i] == 16'd0)
                        ch_running[i] = 1'b0;
                end
                ch_start[i]      = ch_start[i] + ch_period[i];
                res              = '0;
                res.slot         = SLOT_W'(i + 1);
                res.fired        = 1'b1;
                res.repeats_left = ch_left[i];
                due_results_q.push_back(res);
                fires++;
            end
        end
        if (fires == 0) begin
            res      = '0;
            res.last = 1'b1;
            due_results_q.push_back(res);
        end else begin
            due_results_q[due_results_q.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Compare each strobed result with the oldest prediction, then log new transactions
    always @(posedge i_clk) begin : result_check
        pctt_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                results_seen++;
                if (o_result.fired)
                    fires_seen++;
                if (due_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %0h",
                             $time, o_result);
                end else begin
                    want = due_results_q.pop_front();
                    check_field("slot", 32'(want.slot), 32'(o_result.slot));
                    check_field("fired", 32'(want.fired), 32'(o_result.fired));
                    check_field("repeats_left", 32'(want.repeats_left),
                                32'(o_result.repeats_left));
                    check_field("last", 32'(want.last), 32'(o_result.last));
                end
            end
            if (start && !busy)
                predict_timer_results(i_item);
        end
    end

    function automatic pctt_pkg::t_in_item poll_at(logic [31:0] now);
        pctt_pkg::t_in_item it;
        it.cmd          = pctt_pkg::CMD_POLL;
        it.now_ms       = now;
        it.period_ms    = $urandom;
        it.repeat_count = 16'($urandom);
        return it;
    endfunction

    function automatic pctt_pkg::t_in_item reg_at(logic [31:0] now, logic [31:0] per,
                                                  logic [15:0] rep);
        pctt_pkg::t_in_item it;
        it.cmd          = pctt_pkg::CMD_REG;
        it.now_ms       = now;
        it.period_ms    = per;
        it.repeat_count = rep;
        return it;
    endfunction

    // Drive one transaction and hold it until the block takes it; start stays high
    task automatic send_command(pctt_pkg::t_in_item cmd_item);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd_item;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and let every owed result come out
    task automatic wait_for_idle();
        start <= 1'b0;
        while (due_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_table_poll();
        send_command(poll_at(32'hFFFF_FFFF));
        wait_for_idle();
    endtask

    // Channels that hit time wrap, zero period, endless count, single shot, zero count
    task automatic test_channel_registration();
        send_command(reg_at(32'hFFFF_FFF0, 32'd32, 16'd2));
        send_command(reg_at(32'hFFFF_FFF8, 32'd0, 16'd3));
        send_command(reg_at(32'hFFFF_FFF8, 32'hFFFF_FFFF, pctt_pkg::FOREVER_CODE));
        send_command(reg_at(32'h0000_0000, 32'd1, 16'd1));
        send_command(reg_at(32'h0000_0000, 32'h40, 16'd0));
        wait_for_idle();
    endtask

    // Walk time across the wrap: multiple fires, stops, catch-up and an empty poll
    task automatic test_expiry_sequence();
        send_command(poll_at(32'h0000_0000));
        send_command(poll_at(32'h0000_0001));
        send_command(poll_at(32'h0000_0010));
        send_command(poll_at(32'h0000_0010));
        send_command(poll_at(32'h0000_0100));
        send_command(poll_at(32'h0000_0101));
        send_command(poll_at(32'h0000_0102));
        send_command(poll_at(32'hFFFF_FFF7));
        wait_for_idle();
        // poll right at the last expiry of the zero-count channel: nothing is due
        send_command(poll_at(ch_start[4]));
        wait_for_idle();
    endtask

    // Claim the remaining slots, then try to register into a full table
    task automatic test_full_table();
        int spare;
        spare = SLOTS - ch_used;
        for (int k = 0; k < spare; k++) begin
            if (k == 0)
                send_command(reg_at(ch_start[4], $urandom_range(5, 40),
                                    pctt_pkg::FOREVER_CODE));
            else
                send_command(reg_at(ch_start[4] + k, $urandom_range(0, 30),
                                    16'($urandom_range(30, 150))));
        end
        send_command(reg_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, pctt_pkg::FOREVER_CODE));
        send_command(reg_at(32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_command(reg_at($urandom, $urandom, 16'($urandom)));
        wait_for_idle();
    endtask

    // Mostly polls with time moving forward, some jumps, stray times and rejected registers
    task automatic test_random_traffic();
        logic [31:0] tnow;
        int          pick;
        tnow = ch_start[4];
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= 150 && n < 300) ? 0 : 7;
            pick     = $urandom_range(0, 99);
            if (pick < 4) begin
                send_command(reg_at($urandom, $urandom, 16'($urandom)));
            end else if (pick < 8) begin
                send_command(poll_at($urandom));
            end else begin
                if (pick < 18)
                    tnow += $urandom_range(25, 300);
                else
                    tnow += $urandom_range(0, 24);
                send_command(poll_at(tnow));
            end
        end
        idle_pct = 7;
        wait_for_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table_poll();
        test_channel_registration();
        test_expiry_sequence();
        test_full_table();
        test_random_traffic();
        $display("Covered %0d register and %0d poll transactions, %0d rejected as table full.",
                 reg_sent, poll_sent, rejects_seen);
        $display("Checked %0d results, %0d of them channel expiries; %0d mismatches.",
                 results_seen, fires_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
